FILE: hdl/mbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbp_pkg;

  // default accumulator and counter width
  localparam int LEN_WIDTH_DEF = 32;

  // framing characters
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_PREFIX   = 3'd1;
  localparam logic [2:0] ERR_DIGIT    = 3'd2;
  localparam logic [2:0] ERR_ZERO     = 3'd3;
  localparam logic [2:0] ERR_TRUNC    = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW = 3'd5;

  // parser phase
  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_DIGITS,
    PH_PAYLOAD,
    PH_TERM,
    PH_DONE,
    PH_SKIP
  } phase_t;

  // header nesting level, doubles as header kind
  typedef enum logic [1:0] {
    LV_ENTRY,
    LV_ARGC,
    LV_ARGLEN
  } level_t;

  // one input byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } mbp_item_t;

  // one result
  typedef struct packed {
    logic [7:0]  data_out;
    logic        is_payload;
    logic        header_done;
    logic [1:0]  header_kind;
    logic [31:0] header_value;
    logic        arg_done;
    logic        cmd_done;
    logic        entry_done;
    logic        trailing;
    logic [2:0]  error_code;
  } mbp_result_t;

endpackage

`default_nettype wire

FILE: hdl/mbp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module mbp_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mbp_pkg::mbp_item_t in_item,
  input  wire logic              adv,
  output logic                   stage_valid,
  output mbp_pkg::mbp_item_t     stage_item
);
  import mbp_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  mbp_item_t  item_r;

  // take a new byte when empty or when the held one moves on
  assign in_ready = !valid_r || adv;

  always_comb begin
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign stage_valid = valid_r;
  assign stage_item  = item_r;

endmodule

`default_nettype wire

FILE: hdl/mbp_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module mbp_parse #(
  parameter int LEN_WIDTH = mbp_pkg::LEN_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire mbp_pkg::mbp_item_t item,
  output mbp_pkg::mbp_result_t    res
);
  import mbp_pkg::*;

  phase_t               phase_r, phase_nxt;
  level_t               level_r, level_nxt;
  logic [LEN_WIDTH-1:0] acc_r, acc_nxt;
  logic [LEN_WIDTH-1:0] cmds_r, cmds_nxt;
  logic [LEN_WIDTH-1:0] args_r, args_nxt;
  logic [LEN_WIDTH-1:0] pay_r, pay_nxt;

  logic [3:0]             digit;
  logic [LEN_WIDTH+3:0]   acc_wide;
  logic [LEN_WIDTH+3:0]   acc_times10;
  logic [LEN_WIDTH+31:0]  acc_ext;
  logic                   finished;
  logic [2:0]             err;

  // accumulator times ten plus digit, with carry-out bits for overflow
  assign digit       = 4'(item.data_byte - CH_ZERO);
  assign acc_wide    = {4'b0000, acc_r};
  assign acc_times10 = (acc_wide << 3) + (acc_wide << 1) + {{LEN_WIDTH{1'b0}}, digit};
  assign acc_ext     = {32'd0, acc_r};

  // next state and result
  always_comb begin
    phase_nxt = phase_r;
    level_nxt = level_r;
    acc_nxt   = acc_r;
    cmds_nxt  = cmds_r;
    args_nxt  = args_r;
    pay_nxt   = pay_r;
    finished  = 1'b0;
    err       = ERR_NONE;
    res              = '0;
    res.data_out     = item.data_byte;

    case (phase_r)
      PH_PREFIX: begin
        if (item.data_byte != ((level_r == LV_ARGLEN) ? CH_DOLLAR : CH_STAR)) begin
          err = ERR_PREFIX;
        end else begin
          acc_nxt   = '0;
          phase_nxt = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        if (item.data_byte == CH_NEWLINE) begin
          res.header_done  = 1'b1;
          res.header_kind  = level_r;
          res.header_value = acc_ext[31:0];
          case (level_r)
            LV_ENTRY: begin
              if (acc_r == '0) begin
                err = ERR_ZERO;
              end else begin
                cmds_nxt  = acc_r;
                level_nxt = LV_ARGC;
                phase_nxt = PH_PREFIX;
              end
            end
            LV_ARGC: begin
              if (acc_r == '0) begin
                err = ERR_ZERO;
              end else begin
                args_nxt  = acc_r;
                level_nxt = LV_ARGLEN;
                phase_nxt = PH_PREFIX;
              end
            end
            default: begin
              pay_nxt   = acc_r;
              phase_nxt = (acc_r == '0) ? PH_TERM : PH_PAYLOAD;
            end
          endcase
        end else if (!(item.data_byte inside {[CH_ZERO:CH_NINE]})) begin
          err = ERR_DIGIT;
        end else if (acc_times10[LEN_WIDTH+3:LEN_WIDTH] != 4'd0) begin
          err = ERR_OVERFLOW;
        end else begin
          acc_nxt = acc_times10[LEN_WIDTH-1:0];
        end
      end
      PH_PAYLOAD: begin
        res.is_payload = 1'b1;
        pay_nxt        = pay_r - LEN_WIDTH'(1);
        if (pay_r == LEN_WIDTH'(1)) begin
          phase_nxt = PH_TERM;
        end
      end
      PH_TERM: begin
        res.arg_done = 1'b1;
        args_nxt     = args_r - LEN_WIDTH'(1);
        if (args_r == LEN_WIDTH'(1)) begin
          res.cmd_done = 1'b1;
          cmds_nxt     = cmds_r - LEN_WIDTH'(1);
          if (cmds_r == LEN_WIDTH'(1)) begin
            res.entry_done = 1'b1;
            finished       = 1'b1;
            phase_nxt      = PH_DONE;
          end else begin
            level_nxt = LV_ARGC;
            phase_nxt = PH_PREFIX;
          end
        end else begin
          level_nxt = LV_ARGLEN;
          phase_nxt = PH_PREFIX;
        end
      end
      PH_DONE: begin
        res.trailing = 1'b1;
        finished     = 1'b1;
      end
      default: begin
        finished = 1'b1;
      end
    endcase

    // buffer ended before the entry completed
    if (err == ERR_NONE && item.last_byte && !finished) begin
      err = ERR_TRUNC;
    end

    // an error blanks every flag and skips to the end of the buffer
    if (err != ERR_NONE) begin
      res           = '0;
      res.data_out  = item.data_byte;
      phase_nxt     = PH_SKIP;
    end
    res.error_code = err;

    // end of buffer returns to the reset state
    if (item.last_byte) begin
      phase_nxt = PH_PREFIX;
      level_nxt = LV_ENTRY;
      acc_nxt   = '0;
      cmds_nxt  = '0;
      args_nxt  = '0;
      pay_nxt   = '0;
    end
  end

  // parser state, updated once per byte transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREFIX;
      level_r <= LV_ENTRY;
      acc_r   <= '0;
      cmds_r  <= '0;
      args_r  <= '0;
      pay_r   <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      level_r <= level_nxt;
      acc_r   <= acc_nxt;
      cmds_r  <= cmds_nxt;
      args_r  <= args_nxt;
      pay_r   <= pay_nxt;
    end
  end

`ifndef SYNTH
  // errors never carry flags
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.error_code != ERR_NONE) |->
      (!res.is_payload && !res.header_done && !res.arg_done && !res.trailing))
    else $error("flags set on an error byte");

  // end of entry implies end of command and argument
  a_done_nest: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.entry_done) |-> (res.cmd_done && res.arg_done))
    else $error("entry_done without cmd_done and arg_done");

  // last byte of a buffer restarts the parser
  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && item.last_byte) |=> (phase_r == PH_PREFIX && level_r == LV_ENTRY))
    else $error("parser did not restart after the last byte");

  // payload is only flagged in the payload phase
  a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
    res.is_payload |-> (phase_r == PH_PAYLOAD))
    else $error("payload flag outside payload phase");
`endif

endmodule

`default_nettype wire

FILE: hdl/mbp_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module mbp_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire mbp_pkg::mbp_result_t res,
  output logic                      load_ok,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output mbp_pkg::mbp_result_t      out_res
);
  import mbp_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  mbp_result_t res_r;

  // room for a new result when empty or being drained
  assign load_ok = !valid_r || out_ready;

  always_comb begin
    if (adv) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

FILE: hdl/multibulk_command_parser_top.sv
// a byte transferred in is held in the input register, then its result in the result register
// throughput: one byte per cycle; in_ready drops only while a result is held
// by a stalled out_ready and the input register is full
// reset: synchronous active-low rst_n empties both registers and returns the
// parser to the start of an entry
`timescale 1ns / 1ps
`default_nettype none

module multibulk_command_parser_top #(
  parameter int LEN_WIDTH = mbp_pkg::LEN_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_data_out,
  output logic             out_is_payload,
  output logic             out_header_done,
  output logic [1:0]       out_header_kind,
  output logic [31:0]      out_header_value,
  output logic             out_arg_done,
  output logic             out_cmd_done,
  output logic             out_entry_done,
  output logic             out_trailing,
  output logic [2:0]       out_error_code
);
  import mbp_pkg::*;

  mbp_item_t   in_item;
  mbp_item_t   stage_item;
  logic        stage_valid;
  logic        load_ok;
  logic        adv;
  mbp_result_t res;
  mbp_result_t out_res;

  // pack the input fields, byte above the last flag
  assign in_item = {in_data_byte, in_last_byte};

  // a held byte moves into the result register when there is room
  assign adv = stage_valid && load_ok;

  mbp_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .adv         (adv),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  mbp_parse #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (stage_item),
    .res   (res)
  );

  mbp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .res       (res),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_data_out     = out_res.data_out;
  assign out_is_payload   = out_res.is_payload;
  assign out_header_done  = out_res.header_done;
  assign out_header_kind  = out_res.header_kind;
  assign out_header_value = out_res.header_value;
  assign out_arg_done     = out_res.arg_done;
  assign out_cmd_done     = out_res.cmd_done;
  assign out_entry_done   = out_res.entry_done;
  assign out_trailing     = out_res.trailing;
  assign out_error_code   = out_res.error_code;

endmodule

`default_nettype wire
